/* rtl/core/cmmn_pkg.sv */
// Package for the column min-max normalizer: sizes, command and status codes, payload types.
`default_nettype none

package cmmn_pkg;

  localparam int COLUMNS     = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int COLUMN_AW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int FRAC_BITS   = 16;
  localparam int SCALED_BITS = FRAC_BITS + 1;
  localparam int CNT_BITS    = $clog2(FRAC_BITS);

  localparam logic [SCALED_BITS-1:0] SCALED_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [1:0] CMD_CLEAR     = 2'd0;
  localparam logic [1:0] CMD_OBSERVE   = 2'd1;
  localparam logic [1:0] CMD_NORMALIZE = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SAT    = 2'd1;
  localparam logic [1:0] STAT_FLAT   = 2'd2;
  localparam logic [1:0] STAT_UNSEEN = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         column;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SCALED_BITS-1:0] scaled;
    logic [1:0]             status;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/column_min_max_normalizer_top.sv */
// Per-column min-max statistics and Q1.16 normalization of signed Q16.16 samples.
//
// Input channel (in_valid, in_stall, in_data) carries commands: clear drops the
// statistics of every column, observe folds a sample into its column's minimum
// and maximum, normalize answers (sample - min) / (max - min) on the output
// channel (out_valid, out_stall, out_data). Clear and observe give no result.
// The block works on one transaction at a time. Clear acts on acceptance, and
// observe reads the memories, then writes back. Normalize reads the memories,
// then evaluates; if compares alone do not settle the answer, the radix-2
// divider makes one quotient bit per cycle. Last, the answer loads the output
// register.
// Minimum and maximum live in two 16-entry memories with a registered read;
// the per-column seen bits are flip-flops. Reset clears the seen bits, the
// state machine and the output valid; the memories are not cleared.
// A result waits in the output register while out_stall is high; the next
// transaction is still accepted, and a further result waits in the sequencer
// until the output register frees up.
`default_nettype none

module column_min_max_normalizer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmmn_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmmn_pkg::out_item_t out_data
);
  import cmmn_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] word_t;
  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DIV, ST_RESP} state_t;

  localparam word_t SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  word_t low_mem  [COLUMNS];
  word_t high_mem [COLUMNS];

  state_t                 state_r, state_nxt;
  logic [1:0]             cmd_r, cmd_nxt;
  logic                   col_ok_r, col_ok_nxt;
  logic [COLUMN_AW-1:0]   idx_r, idx_nxt;
  word_t                  samp_r, samp_nxt;
  logic [COLUMNS-1:0]     seen_r, seen_nxt;
  word_t                  low_rd_r, high_rd_r;
  word_t                  rem_r, rem_nxt;
  word_t                  den_r, den_nxt;
  logic [FRAC_BITS-1:0]   quo_r, quo_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  out_item_t              res_r, res_nxt;
  out_item_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic [COLUMN_AW-1:0]   in_idx;
  logic                   low_we, high_we;
  logic                   seen_hit;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS+1:0] trial;
  logic                   take;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_idx    = COLUMN_AW'(in_data.column);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign seen_hit = col_ok_r && seen_r[idx_r];
  assign shifted  = {rem_r, 1'b0};
  assign trial    = {1'b0, shifted} - {2'b00, den_r};
  assign take     = !trial[SAMPLE_BITS+1];

  // Bounds are read in the cycle after acceptance and written back from the
  // evaluation cycle; only one transaction is in flight, so no forwarding.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      low_rd_r  <= low_mem[in_idx];
      high_rd_r <= high_mem[in_idx];
    end
    if (low_we) begin
      low_mem[idx_r] <= samp_r;
    end
    if (high_we) begin
      high_mem[idx_r] <= samp_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_ok_nxt    = col_ok_r;
    idx_nxt       = idx_r;
    samp_nxt      = samp_r;
    seen_nxt      = seen_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    low_we        = 1'b0;
    high_we       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.cmd)
            CMD_CLEAR: begin
              seen_nxt = '0;
            end
            CMD_OBSERVE, CMD_NORMALIZE: begin
              cmd_nxt    = in_data.cmd;
              idx_nxt    = in_idx;
              col_ok_nxt = (int'(in_data.column) < COLUMNS);
              // Offset binary makes unsigned compares follow the signed order.
              samp_nxt   = word_t'(in_data.sample) ^ SIGN_BIT;
              state_nxt  = ST_EVAL;
            end
            default: begin
            end
          endcase
        end
      end

      ST_EVAL: begin
        if (cmd_r == CMD_OBSERVE) begin
          if (col_ok_r) begin
            if (!seen_r[idx_r]) begin
              seen_nxt[idx_r] = 1'b1;
              low_we          = 1'b1;
              high_we         = 1'b1;
            end else if (samp_r < low_rd_r) begin
              low_we = 1'b1;
            end else if (samp_r > high_rd_r) begin
              high_we = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
          if (!seen_hit) begin
            res_nxt = '{scaled: '0, status: STAT_UNSEEN};
          end else if (high_rd_r == low_rd_r) begin
            res_nxt = '{scaled: '0, status: STAT_FLAT};
          end else if (samp_r < low_rd_r) begin
            res_nxt = '{scaled: '0, status: STAT_SAT};
          end else if (samp_r > high_rd_r) begin
            res_nxt = '{scaled: SCALED_ONE, status: STAT_SAT};
          end else if (samp_r == high_rd_r) begin
            res_nxt = '{scaled: SCALED_ONE, status: STAT_OK};
          end else begin
            rem_nxt   = samp_r - low_rd_r;
            den_nxt   = high_rd_r - low_rd_r;
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_nxt = take ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], take};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(FRAC_BITS - 1)) begin
          res_nxt   = '{scaled: {1'b0, quo_nxt}, status: STAT_OK};
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    col_ok_r <= col_ok_nxt;
    idx_r    <= idx_nxt;
    samp_r   <= samp_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  // A new result only ever comes from the response state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result appeared outside the response state");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  // Any status other than ok comes with a pinned value of zero or one.
  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STAT_OK |->
      out_r.scaled == '0 || out_r.scaled == SCALED_ONE)
    else $error("non-ok status with a fractional value");

  // The scaled value never exceeds 1.0.
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.scaled <= SCALED_ONE)
    else $error("scaled value above one");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the column min-max normalizer: directed table, then random traffic.
`default_nettype none

module testbench;
  import cmmn_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1700;
  localparam int SENDER_QUIET_LO = 200;
  localparam int SENDER_QUIET_HI = 700;
  localparam int HOLD_AT_ITEM    = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int RX_QUIET_CYCLES = 1500;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Statistics kept in offset-binary form so that unsigned compares follow signed order.
  logic [SAMPLE_BITS-1:0] col_min_biased [COLUMNS];
  logic [SAMPLE_BITS-1:0] col_max_biased [COLUMNS];
  logic [COLUMNS-1:0]     col_seen;

  out_item_t   pending_results[$];
  stim_row_t   stim_table[$];
  int          error_count;
  int          cycle_count;
  int          items_sent;
  bit          hold_request;
  bit          hold_done;
  int          rx_quiet_left;

  column_min_max_normalizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL column_min_max_normalizer_top");
    $finish;
  end

  function automatic logic [SAMPLE_BITS-1:0] to_biased(input logic [31:0] raw);
    logic [SAMPLE_BITS-1:0] b;
    b = raw[SAMPLE_BITS-1:0];
    b[SAMPLE_BITS-1] = ~b[SAMPLE_BITS-1];
    return b;
  endfunction

  // Restoring division, one quotient bit per step; num is below den.
  function automatic logic [FRAC_BITS-1:0] fraction_of(input logic [SAMPLE_BITS-1:0] num,
                                                       input logic [SAMPLE_BITS-1:0] den);
    logic [SAMPLE_BITS+1:0] rem;
    logic [SAMPLE_BITS+1:0] div;
    logic [FRAC_BITS-1:0]   q;
    rem = num;
    div = den;
    q   = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= div) begin
        rem  = rem - div;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Applies one command to the statistics; returns 1 when the command answers.
  function automatic bit apply_command(input in_item_t it, output out_item_t res);
    logic [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    s   = to_biased(it.sample);
    res = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        col_seen = '0;
        return 1'b0;
      end
      CMD_OBSERVE: begin
        if (int'(it.column) < COLUMNS) begin
          if (!col_seen[it.column]) begin
            col_seen[it.column]       = 1'b1;
            col_min_biased[it.column] = s;
            col_max_biased[it.column] = s;
          end else if (s < col_min_biased[it.column]) begin
            col_min_biased[it.column] = s;
          end else if (s > col_max_biased[it.column]) begin
            col_max_biased[it.column] = s;
          end
        end
        return 1'b0;
      end
      CMD_NORMALIZE: begin
        if (int'(it.column) >= COLUMNS || !col_seen[it.column]) begin
          res.status = STAT_UNSEEN;
        end else begin
          lo = col_min_biased[it.column];
          hi = col_max_biased[it.column];
          if (hi == lo) begin
            res.status = STAT_FLAT;
          end else if (s < lo) begin
            res.status = STAT_SAT;
          end else if (s > hi) begin
            res.scaled = SCALED_ONE;
            res.status = STAT_SAT;
          end else if (s == hi) begin
            res.scaled = SCALED_ONE;
            res.status = STAT_OK;
          end else begin
            res.scaled = {1'b0, fraction_of(s - lo, hi - lo)};
            res.status = STAT_OK;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Picks a sample that often lands on or near the column's current bounds.
  function automatic logic [31:0] pick_sample(input int col);
    int unsigned            pick;
    int                     smallv;
    logic [SAMPLE_BITS-1:0] lo_b;
    logic [SAMPLE_BITS-1:0] hi_b;
    logic [63:0]            prod;
    pick = $urandom_range(0, 9);
    if (!col_seen[col] && pick >= 3) pick = pick % 3;
    lo_b = col_min_biased[col];
    hi_b = col_max_biased[col];
    case (pick)
      0, 1: return $urandom();
      2: begin
        smallv = int'($urandom_range(0, 8000)) - 4000;
        return smallv * 64;
      end
      3: return to_biased(lo_b);
      4: return to_biased(hi_b);
      5: return to_biased(lo_b) - 32'd1;
      6: return to_biased(hi_b) + 32'd1;
      default: begin
        prod = {32'd0, $urandom()} * {32'd0, hi_b - lo_b};
        return to_biased(lo_b + prod[63:32]);
      end
    endcase
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [3:0] col, input logic [31:0] smp,
                         input bit typed, input logic [SCALED_BITS-1:0] scaled,
                         input logic [1:0] status);
    stim_row_t r;
    r.item.cmd     = cmd;
    r.item.column  = col;
    r.item.sample  = smp;
    r.typed        = typed;
    r.result.scaled = scaled;
    r.result.status = status;
    stim_table.insert(stim_table.size(), r);
  endtask

  // Offers one transaction until it is taken, then records what it should answer.
  task automatic deliver(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    bit        quiet;
    quiet = (items_sent >= SENDER_QUIET_LO && items_sent < SENDER_QUIET_HI);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (apply_command(it, res)) begin
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
    end
    items_sent++;
    if (items_sent == HOLD_AT_ITEM) hold_request = 1'b1;
  endtask

  // Result side: random stalls, one long hold-off, then a stretch without stalls.
  initial begin
    hold_done     = 1'b0;
    rx_quiet_left = 0;
    out_stall    <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_quiet_left = RX_QUIET_CYCLES;
      end else if (rx_quiet_left > 0) begin
        rx_quiet_left--;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: scaled %0d status %0d",
               out_data.scaled, out_data.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.scaled !== want.scaled) begin
          $error("scaled: expected %0d, actual %0d", want.scaled, out_data.scaled);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t none;
    int        counted;
    int        r;
    error_count  = 0;
    items_sent   = 0;
    hold_request = 1'b0;
    none         = '0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset state, full-range column, flat column, out-of-range,
    // the unused command, a column whose minimum moves, and clear.
    add_row(CMD_NORMALIZE, 4'd0,  32'h0000_0000, 1, '0,         STAT_UNSEEN);
    add_row(CMD_NORMALIZE, 4'd15, 32'h7FFF_FFFF, 1, '0,         STAT_UNSEEN);
    add_row(CMD_OBSERVE,   4'd1,  32'h8000_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd1,  32'h7FFF_FFFF, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd1,  32'h8000_0000, 1, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd1,  32'h7FFF_FFFF, 1, SCALED_ONE, STAT_OK);
    add_row(CMD_NORMALIZE, 4'd1,  32'h0000_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd2,  32'h0005_0000, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd2,  32'h0005_0000, 1, '0,         STAT_FLAT);
    add_row(CMD_NORMALIZE, 4'd2,  32'h0000_0000, 1, '0,         STAT_FLAT);
    add_row(CMD_OBSERVE,   4'd3,  32'h0064_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd3,  32'h00C8_0000, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd3,  32'h0032_0000, 1, '0,         STAT_SAT);
    add_row(CMD_NORMALIZE, 4'd3,  32'h012C_0000, 1, SCALED_ONE, STAT_SAT);
    add_row(CMD_NORMALIZE, 4'd3,  32'h00C8_0000, 1, SCALED_ONE, STAT_OK);
    add_row(CMD_NORMALIZE, 4'd3,  32'h0096_0000, 1, 17'd32768,  STAT_OK);
    add_row(CMD_UNUSED,    4'd3,  32'h0000_0000, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd3,  32'h00AF_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd3,  32'hFFFF_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd3,  32'h0096_0000, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd3,  32'h0000_0000, 0, '0,         STAT_OK);
    add_row(CMD_OBSERVE,   4'd15, 32'hFFFF_FFFF, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd15, 32'hFFFF_FFFF, 1, '0,         STAT_FLAT);
    add_row(CMD_CLEAR,     4'd0,  32'h0000_0000, 0, '0,         STAT_OK);
    add_row(CMD_NORMALIZE, 4'd1,  32'h0000_0000, 1, '0,         STAT_UNSEEN);

    foreach (stim_table[i]) deliver(stim_table[i].item, stim_table[i].typed,
                                    stim_table[i].result);

    // Random traffic: mostly observe and normalize on a few busy columns, rare clears,
    // and a little of the unused command, which does not count.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 999);
      if (r < 10)       it.cmd = CMD_CLEAR;
      else if (r < 40)  it.cmd = CMD_UNUSED;
      else if (r < 520) it.cmd = CMD_OBSERVE;
      else              it.cmd = CMD_NORMALIZE;
      it.column = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
      it.sample = pick_sample(int'(it.column));
      if (it.cmd != CMD_UNUSED) counted++;
      deliver(it, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS column_min_max_normalizer_top");
    end else begin
      $display("FAIL column_min_max_normalizer_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
